// File: hw/rtl/mjq_pkg.sv
// shared constants and types for the minimum-jerk quintic coefficient pipeline
package mjq_pkg;

  localparam int WORD_W = 32;
  localparam int DUR_W  = 24;
  localparam int FRAC_W = 16;
  localparam int NK     = 3;
  localparam int IN_W   = 6 * WORD_W + DUR_W;
  localparam int OUT_W  = ((6 * WORD_W + 2 + 7) / 8) * 8;
  localparam int ERR_LSB = 6 * WORD_W;
  localparam int XW     = 62;
  localparam int PW     = 88;
  localparam int DW     = 160;
  localparam int QB     = 33;
  localparam int NDIV   = QB + 1;
  localparam int NPRE   = 6;
  localparam int NST    = NPRE + NDIV + 1;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_DUR_ZERO = 2'd1,
    ERR_SAT      = 2'd2
  } err_e;

  typedef struct packed {
    logic [WORD_W-1:0] a0;
    logic [WORD_W-1:0] a1;
    logic [WORD_W-1:0] a2;
    logic              tz;
  } pass_t;

  typedef struct packed {
    logic [NK-1:0][DW-1:0] rem;
    logic [NK-1:0][DW-1:0] dsr;
    logic [NK-1:0][QB-1:0] quo;
    logic [NK-1:0]         ovf;
    logic [NK-1:0]         neg;
    logic [NK-1:0]         zero;
  } div_t;

endpackage

// File: hw/rtl/min_jerk_quintic_coeffs.sv
// minimum-jerk quintic coefficients: polynomial setup, powers of T, restoring dividers
// 41 register stages; one request per cycle while the master side does not stall
// the dividers are an overflow check and 33 quotient-bit stages
// a stall on the master side freezes every stage, nothing is dropped or repeated
// reset clears the stage valid bits only, data registers are not reset
module min_jerk_quintic_coeffs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // start_pos, start_vel, start_acc, goal_pos, goal_vel, goal_acc, duration
  input  logic [mjq_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // coef_a0, coef_a1, coef_a2, coef_a3, coef_a4, coef_a5, error_code, zero pad
  output logic [mjq_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import mjq_pkg::*;

  logic en;
  logic [NST-1:0] v_q;
  pass_t pass_q [NST-1];
  pass_t pass_d;

  // stage 1
  logic signed [WORD_W-1:0] sp, sv, sa, gp, gv, ga;
  logic signed [WORD_W:0] dd, de, dh;
  logic [WORD_W:0] a2sum;
  logic [DUR_W-1:0] tin;
  logic signed [35:0] c2_d [NK];
  logic signed [35:0] c2_q [NK];
  logic signed [39:0] c1_d [NK];
  logic signed [39:0] c1_q [NK];
  logic signed [39:0] c0_d [NK];
  logic signed [39:0] c0_q [NK];
  logic [DUR_W-1:0] t1_q;

  // stage 2
  logic signed [60:0] pr [NK];
  logic signed [XW-1:0] x_d [NK];
  logic signed [XW-1:0] x_q [NK];
  logic signed [39:0] c0b_q [NK];
  logic [2*DUR_W-1:0] t2_d, t2_q;
  logic [DUR_W-1:0] tb2_q;

  // stage 3
  logic [53:0] xl_d [NK];
  logic [53:0] xl_q [NK];
  logic signed [56:0] xh_d [NK];
  logic signed [56:0] xh_q [NK];
  logic signed [39:0] c0c_q [NK];
  logic [2*DUR_W-1:0] t3p_d [2];
  logic [2*DUR_W-1:0] t3p_q [2];
  logic [2*DUR_W-1:0] t4p_d [3];
  logic [2*DUR_W-1:0] t4p_q [3];
  logic [DUR_W-1:0] tb3_q;

  // stage 4
  logic signed [PW-1:0] p_d [NK];
  logic signed [PW-1:0] p_q [NK];
  logic [3*DUR_W-1:0] t3_d, t3_q;
  logic [4*DUR_W-1:0] t4_d, t4_q;
  logic [DUR_W-1:0] tb4_q;

  // stage 5
  logic [DW-1:0] m_d [NK];
  logic [DW-1:0] m_q [NK];
  logic [NK-1:0] neg_d, neg_q, zero_d, zero_q;
  logic [2*DUR_W-1:0] t5p_d [4];
  logic [2*DUR_W-1:0] t5p_q [4];
  logic [3*DUR_W-1:0] t3b_q;
  logic [4*DUR_W-1:0] t4b_q;

  // stage 6 and dividers
  div_t s6_d, s6_q;
  div_t dv_src [NDIV];
  div_t dv_d [NDIV];
  div_t dv_q [NDIV];

  // output
  logic [WORD_W-1:0] coef_d [NK];
  logic [NK-1:0] sat_d;
  err_e err_d;
  logic [OUT_W-1:0] out_q;

  assign en = !v_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[NST-1];
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  // stage 1: differences and polynomial coefficients in T
  assign sp  = s_axis_tdata_i[0*WORD_W +: WORD_W];
  assign sv  = s_axis_tdata_i[1*WORD_W +: WORD_W];
  assign sa  = s_axis_tdata_i[2*WORD_W +: WORD_W];
  assign gp  = s_axis_tdata_i[3*WORD_W +: WORD_W];
  assign gv  = s_axis_tdata_i[4*WORD_W +: WORD_W];
  assign ga  = s_axis_tdata_i[5*WORD_W +: WORD_W];
  assign tin = s_axis_tdata_i[6*WORD_W +: DUR_W];

  always_comb begin
    dd = (WORD_W+1)'(gp) - (WORD_W+1)'(sp);
    de = (WORD_W+1)'(gv) - (WORD_W+1)'(sv);
    dh = (WORD_W+1)'(ga) - (WORD_W+1)'(sa);
    c2_d[0] = 36'(dh) - (36'(sa) <<< 1);
    c2_d[1] = 36'(sa) - (36'(dh) <<< 1);
    c2_d[2] = 36'(dh);
    c1_d[0] = -(40'(sv) * 40'sd20 + 40'(de) * 40'sd8);
    c1_d[1] = 40'(sv) * 40'sd30 + 40'(de) * 40'sd14;
    c1_d[2] = -(40'(sv) * 40'sd12 + 40'(de) * 40'sd6);
    c0_d[0] = 40'(dd) * 40'sd20;
    c0_d[1] = -(40'(dd) * 40'sd30);
    c0_d[2] = 40'(dd) * 40'sd12;
    a2sum = {sa[WORD_W-1], sa} + {{WORD_W{1'b0}}, ~sa[WORD_W-1]};
    pass_d.a0 = sp;
    pass_d.a1 = sv;
    pass_d.a2 = a2sum[WORD_W:1];
    pass_d.tz = (tin == '0);
  end

  // stage 2: inner horner step, t squared
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      pr[k]  = c2_q[k] * $signed({1'b0, t1_q});
      x_d[k] = XW'(pr[k]) + (XW'(c1_q[k]) <<< FRAC_W);
    end
    t2_d = t1_q * t1_q;
  end

  // stage 3: partial products of x*t, t^3 and t^4
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      xl_d[k] = x_q[k][29:0] * tb2_q;
      xh_d[k] = $signed(x_q[k][XW-1:30]) * $signed({1'b0, tb2_q});
    end
    t3p_d[0] = t2_q[DUR_W-1:0] * tb2_q;
    t3p_d[1] = t2_q[2*DUR_W-1:DUR_W] * tb2_q;
    t4p_d[0] = t2_q[DUR_W-1:0] * t2_q[DUR_W-1:0];
    t4p_d[1] = t2_q[DUR_W-1:0] * t2_q[2*DUR_W-1:DUR_W];
    t4p_d[2] = t2_q[2*DUR_W-1:DUR_W] * t2_q[2*DUR_W-1:DUR_W];
  end

  // stage 4: numerator polynomial, t^3 and t^4 sums
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      p_d[k] = (PW'(xh_q[k]) <<< 30) + PW'(xl_q[k]) + (PW'(c0c_q[k]) <<< (2 * FRAC_W));
    end
    t3_d = (3*DUR_W)'(t3p_q[0]) + ((3*DUR_W)'(t3p_q[1]) << DUR_W);
    t4_d = (4*DUR_W)'(t4p_q[0]) + ((4*DUR_W)'(t4p_q[1]) << (DUR_W + 1))
         + ((4*DUR_W)'(t4p_q[2]) << (2 * DUR_W));
  end

  // stage 5: magnitude, fraction scaling, t^5 partials
  always_comb begin
    logic [PW-1:0] pa;
    for (int k = 0; k < NK; k++) begin
      pa = p_q[k][PW-1] ? PW'(-p_q[k]) : PW'(p_q[k]);
      m_d[k]    = DW'(pa) << (FRAC_W * (k + 1));
      neg_d[k]  = p_q[k][PW-1];
      zero_d[k] = (p_q[k] == '0);
    end
    for (int i = 0; i < 4; i++) begin
      t5p_d[i] = t4_q[i*DUR_W +: DUR_W] * tb4_q;
    end
  end

  // stage 6: t^5 sum and divider setup
  always_comb begin
    logic [5*DUR_W-1:0] t5;
    t5 = '0;
    for (int i = 0; i < 4; i++) begin
      t5 = t5 + ((5*DUR_W)'(t5p_q[i]) << (i * DUR_W));
    end
    for (int k = 0; k < NK; k++) begin
      s6_d.rem[k] = m_q[k];
    end
    s6_d.dsr[0] = DW'(t3b_q);
    s6_d.dsr[1] = DW'(t4b_q);
    s6_d.dsr[2] = DW'(t5);
    s6_d.quo    = '0;
    s6_d.ovf    = '0;
    s6_d.neg    = neg_q;
    s6_d.zero   = zero_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pass_q[0] <= pass_d;
      for (int i = 1; i < NST - 1; i++) begin
        pass_q[i] <= pass_q[i-1];
      end
      t1_q  <= tin;
      tb2_q <= t1_q;
      t2_q  <= t2_d;
      tb3_q <= tb2_q;
      t3p_q <= t3p_d;
      t4p_q <= t4p_d;
      tb4_q <= tb3_q;
      t3_q  <= t3_d;
      t4_q  <= t4_d;
      t5p_q <= t5p_d;
      t3b_q <= t3_q;
      t4b_q <= t4_q;
      for (int k = 0; k < NK; k++) begin
        c2_q[k]  <= c2_d[k];
        c1_q[k]  <= c1_d[k];
        c0_q[k]  <= c0_d[k];
        x_q[k]   <= x_d[k];
        c0b_q[k] <= c0_q[k];
        xl_q[k]  <= xl_d[k];
        xh_q[k]  <= xh_d[k];
        c0c_q[k] <= c0b_q[k];
        p_q[k]   <= p_d[k];
        m_q[k]   <= m_d[k];
      end
      neg_q  <= neg_d;
      zero_q <= zero_d;
      s6_q   <= s6_d;
    end
  end

  // restoring dividers, first stage checks for quotient overflow
  assign dv_src[0] = s6_q;

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    if (s == 0) begin : g_chk
      always_comb begin
        dv_d[s] = dv_src[s];
        for (int k = 0; k < NK; k++) begin
          dv_d[s].ovf[k] = (dv_src[s].rem[k] >= (dv_src[s].dsr[k] << QB));
        end
      end
    end else begin : g_bit
      assign dv_src[s] = dv_q[s-1];
      always_comb begin
        logic [DW-1:0] sh;
        dv_d[s] = dv_src[s];
        for (int k = 0; k < NK; k++) begin
          sh = dv_src[s].dsr[k] << (QB - s);
          if (dv_src[s].rem[k] >= sh) begin
            dv_d[s].rem[k] = dv_src[s].rem[k] - sh;
            dv_d[s].quo[k][QB-s] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[s] <= dv_d[s];
      end
    end
  end

  // rounding, saturation and error code
  always_comb begin
    logic [QB:0] q;
    for (int k = 0; k < NK; k++) begin
      q = ((QB+1)'(dv_q[NDIV-1].quo[k]) + (QB+1)'(1)) >> 1;
      if (dv_q[NDIV-1].neg[k]) begin
        sat_d[k]  = dv_q[NDIV-1].ovf[k] || (q > (QB+1)'(SAT_MIN));
        coef_d[k] = sat_d[k] ? SAT_MIN : (WORD_W'(0) - q[WORD_W-1:0]);
      end else begin
        sat_d[k]  = dv_q[NDIV-1].ovf[k] || (q > (QB+1)'(SAT_MAX));
        coef_d[k] = sat_d[k] ? SAT_MAX : q[WORD_W-1:0];
      end
      if (pass_q[NST-2].tz) begin
        coef_d[k] = dv_q[NDIV-1].zero[k] ? '0 :
                    (dv_q[NDIV-1].neg[k] ? SAT_MIN : SAT_MAX);
      end
    end
    if (pass_q[NST-2].tz) begin
      err_d = ERR_DUR_ZERO;
    end else if (|sat_d) begin
      err_d = ERR_SAT;
    end else begin
      err_d = ERR_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= OUT_W'({err_d, coef_d[2], coef_d[1], coef_d[0],
                       pass_q[NST-2].a2, pass_q[NST-2].a1, pass_q[NST-2].a0});
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted request did not enter stage one");

  a_zero_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-2] && en && pass_q[NST-2].tz)
    |=> (m_axis_tdata_o[ERR_LSB +: 2] == ERR_DUR_ZERO))
    else $error("zero duration not flagged");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-2] && en && !pass_q[NST-2].tz && (|dv_q[NDIV-1].ovf))
    |=> (m_axis_tdata_o[ERR_LSB +: 2] == ERR_SAT))
    else $error("quotient overflow not flagged");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-2] && !pass_q[NST-2].tz)
    |-> ((dv_q[NDIV-1].ovf[0] || dv_q[NDIV-1].rem[0] < dv_q[NDIV-1].dsr[0]) &&
         (dv_q[NDIV-1].ovf[1] || dv_q[NDIV-1].rem[1] < dv_q[NDIV-1].dsr[1]) &&
         (dv_q[NDIV-1].ovf[2] || dv_q[NDIV-1].rem[2] < dv_q[NDIV-1].dsr[2])))
    else $error("divider remainder not below divisor");
`endif

endmodule
